// ===== sv/u2a_pkg.sv =====
// u2a_pkg: types, constants and helpers for the unsigned-to-ASCII digit unit.
// Used by u2a_conv, u2a_emit and unsigned_to_ascii_digits_unit. No dependencies.
package u2a_pkg;

    localparam int VALUE_BITS = 32;
    // Input field is 32 bits wide, so the value never exceeds 32 bits.
    localparam int VAL_W      = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    // Decimal digit count: floor(VAL_W * log10(2)) + 1.
    localparam int NUM_DIGITS = ((VAL_W * 1233) >> 12) + 1;
    localparam int DIG_W      = NUM_DIGITS * 4;
    localparam int CNT_W      = $clog2(VAL_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A    = 7'h61;

    typedef struct packed {
        logic        func;
        logic [31:0] value;
    } t_in_req;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last_digit;
    } t_out_res;

    // Converter to emitter handoff
    typedef struct packed {
        logic             valid;
        logic [DIG_W-1:0] digits;
    } t_conv_out;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } t_conv_state;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SEND
    } t_emit_state;

    function automatic logic [6:0] digit_to_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'd0, d};
        end else begin
            c = CHAR_A + {3'd0, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

// ===== sv/unsigned_to_ascii_digits_unit.sv =====
// Conversion runs bit-serially through the shift/add-3 loop (one bit/cycle); a new request is
//   accepted only once the previous result has been handed to the emitter. Characters then
//   leave one per cycle while i_out_ready is high, at most 10, overlapped with the next conversion.
// Reset (i_rst_n, synchronous, active low) clears the converter and emitter control state
//   and drops any pending output character; no other state is kept between requests.
// Depends on u2a_pkg, u2a_conv, u2a_emit.
module unsigned_to_ascii_digits_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  u2a_pkg::t_in_req       i_in_req,
    // character channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output u2a_pkg::t_out_res      o_out_res
);

    // Converter holds finished digits (BCD for decimal, raw nibbles for hex)
    // until the emitter is free, so a new request can be converted while the
    // previous run's characters are still leaving.
    u2a_pkg::t_conv_out w_conv;
    logic               w_take;

    // Hex mode runs the same shift register with the add-3 step disabled,
    // which leaves the value's nibbles in place as hex digits.
    u2a_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_req),
        .o_res   (w_conv),
        .i_take  (w_take)
    );

    // Emitter skips leading zero digits (keeping at least one, so zero gives
    // '0'), then sends one character per cycle through an output register
    // that stalls only on i_out_ready.
    u2a_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_conv  (w_conv),
        .o_take  (w_take),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_res)
    );

endmodule

// ===== sv/u2a_conv.sv =====
// u2a_conv: bit-serial binary to BCD / hex nibble converter (shift and add-3).
// Depends on u2a_pkg.
module u2a_conv (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  u2a_pkg::t_in_req       i_req,
    output u2a_pkg::t_conv_out     o_res,
    input  logic                   i_take
);

    u2a_pkg::t_conv_state r_state, n_state;
    logic [u2a_pkg::VAL_W-1:0] r_bin, n_bin;
    logic [u2a_pkg::DIG_W-1:0] r_bcd, n_bcd;
    logic [u2a_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_dec, n_dec;
    logic [u2a_pkg::DIG_W-1:0] w_corr;
    logic                      w_bcd_ok;

    // add-3 correction, one narrow adder per digit (decimal only)
    always_comb begin
        w_corr   = r_bcd;
        w_bcd_ok = 1'b1;
        for (int i = 0; i < u2a_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] > 4'd9) begin
                w_bcd_ok = 1'b0;
            end
            if (r_dec && (r_bcd[i*4 +: 4] >= 4'd5)) begin
                w_corr[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            u2a_pkg::CONV_IDLE: begin
                if (i_valid) begin
                    n_state = u2a_pkg::CONV_RUN;
                end
            end
            u2a_pkg::CONV_RUN: begin
                if (r_cnt == '0) begin
                    n_state = u2a_pkg::CONV_DONE;
                end
            end
            u2a_pkg::CONV_DONE: begin
                if (i_take) begin
                    n_state = u2a_pkg::CONV_IDLE;
                end
            end
            default: n_state = u2a_pkg::CONV_IDLE;
        endcase
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        n_dec = r_dec;
        unique case (r_state)
            u2a_pkg::CONV_IDLE: begin
                n_bin = i_req.value[u2a_pkg::VAL_W-1:0];
                n_bcd = '0;
                n_cnt = u2a_pkg::CNT_W'(u2a_pkg::VAL_W - 1);
                n_dec = i_req.func;
            end
            u2a_pkg::CONV_RUN: begin
                n_bcd = {w_corr[u2a_pkg::DIG_W-2:0], r_bin[u2a_pkg::VAL_W-1]};
                n_bin = {r_bin[u2a_pkg::VAL_W-2:0], 1'b0};
                n_cnt = r_cnt - u2a_pkg::CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_ready      = (r_state == u2a_pkg::CONV_IDLE);
        o_res.valid  = (r_state == u2a_pkg::CONV_DONE);
        o_res.digits = r_bcd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u2a_pkg::CONV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_dec <= n_dec;
    end

    // decimal digits stay legal BCD throughout the conversion
    a_bcd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u2a_pkg::CONV_RUN && r_dec) |-> w_bcd_ok)
        else $error("BCD digit out of range during conversion");

    // a request starts the run with a full bit count
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u2a_pkg::CONV_IDLE && i_valid) |=>
        (r_state == u2a_pkg::CONV_RUN && r_cnt == u2a_pkg::CNT_W'(u2a_pkg::VAL_W - 1)))
        else $error("conversion did not start correctly");

    // result held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u2a_pkg::CONV_DONE && !i_take) |=>
        (r_state == u2a_pkg::CONV_DONE && $stable(r_bcd)))
        else $error("converted digits lost before handoff");

endmodule

// ===== sv/u2a_emit.sv =====
// u2a_emit: drops leading zero digits and sends ASCII characters one per cycle unless stalled by i_ready.
// Depends on u2a_pkg.
module u2a_emit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  u2a_pkg::t_conv_out     i_conv,
    output logic                   o_take,
    output logic                   o_valid,
    input  logic                   i_ready,
    output u2a_pkg::t_out_res      o_res
);

    u2a_pkg::t_emit_state       r_state, n_state;
    logic [u2a_pkg::DIG_W-1:0]  r_dig, n_dig;
    logic [u2a_pkg::LEFT_W-1:0] r_left, n_left;
    logic                       r_ov, n_ov;
    u2a_pkg::t_out_res          r_res, n_res;
    logic [3:0]                 w_top;
    logic                       w_slot;

    assign w_top  = r_dig[u2a_pkg::DIG_W-1 -: 4];
    assign w_slot = !r_ov || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            u2a_pkg::EMIT_IDLE: begin
                if (i_conv.valid) begin
                    n_state = u2a_pkg::EMIT_SKIP;
                end
            end
            u2a_pkg::EMIT_SKIP: begin
                if (w_top != 4'd0 || r_left == u2a_pkg::LEFT_W'(1)) begin
                    n_state = u2a_pkg::EMIT_SEND;
                end
            end
            u2a_pkg::EMIT_SEND: begin
                if (w_slot && r_left == u2a_pkg::LEFT_W'(1)) begin
                    n_state = u2a_pkg::EMIT_IDLE;
                end
            end
            default: n_state = u2a_pkg::EMIT_IDLE;
        endcase
    end

    always_comb begin
        n_dig  = r_dig;
        n_left = r_left;
        n_ov   = r_ov && !i_ready;
        n_res  = r_res;
        o_take = 1'b0;
        unique case (r_state)
            u2a_pkg::EMIT_IDLE: begin
                o_take = i_conv.valid;
                n_dig  = i_conv.digits;
                n_left = u2a_pkg::LEFT_W'(u2a_pkg::NUM_DIGITS);
            end
            u2a_pkg::EMIT_SKIP: begin
                if (w_top == 4'd0 && r_left != u2a_pkg::LEFT_W'(1)) begin
                    n_dig  = {r_dig[u2a_pkg::DIG_W-5:0], 4'd0};
                    n_left = r_left - u2a_pkg::LEFT_W'(1);
                end
            end
            u2a_pkg::EMIT_SEND: begin
                if (w_slot) begin
                    n_ov             = 1'b1;
                    n_res.digit_char = u2a_pkg::digit_to_char(w_top);
                    n_res.last_digit = (r_left == u2a_pkg::LEFT_W'(1));
                    n_dig            = {r_dig[u2a_pkg::DIG_W-5:0], 4'd0};
                    n_left           = r_left - u2a_pkg::LEFT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u2a_pkg::EMIT_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_dig  <= n_dig;
        r_left <= n_left;
        r_res  <= n_res;
    end

    // digit count never runs out while characters remain to send
    a_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u2a_pkg::EMIT_SEND || r_state == u2a_pkg::EMIT_SKIP) |->
        (r_left != '0))
        else $error("emitter digit count underflow");

    // only digit characters leave the block
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ((r_res.digit_char >= 7'h30 && r_res.digit_char <= 7'h39) ||
                  (r_res.digit_char >= 7'h61 && r_res.digit_char <= 7'h66)))
        else $error("non-digit character emitted");

    // the last character of a run sends the emitter back to idle
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == u2a_pkg::EMIT_SEND && w_slot && r_left == u2a_pkg::LEFT_W'(1)) |=>
        (r_state == u2a_pkg::EMIT_IDLE && r_ov && r_res.last_digit))
        else $error("run did not end with a flagged last digit");

endmodule

// ===== dv/unsigned_to_ascii_digits_unit_tb.sv =====
// Testbench for unsigned_to_ascii_digits_unit: drives number/radix requests and checks every
// ASCII digit character against a local digit predictor, under random idling and back-pressure.
// Depends on u2a_pkg and the RTL of unsigned_to_ascii_digits_unit.
module unsigned_to_ascii_digits_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Radix select codes of the func field
    localparam logic FUNC_HEX = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    // Glyph table, '0' in the top byte
    localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789abcdef";
    localparam logic [31:0] VALUE_MASK = (u2a_pkg::VAL_W >= 32) ? 32'hFFFF_FFFF
                                         : ((32'd1 << u2a_pkg::VAL_W) - 32'd1);

    localparam int RESET_CYCLES  = 6;
    localparam int LONG_HOLD     = 400;   // receiver hold-off for the pressure phase
    localparam int SETTLE_CYCLES = 60;    // longer than the worst request-to-last-character time
    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake before giving up

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_ready;
    u2a_pkg::t_in_req  in_req = '0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    u2a_pkg::t_out_res o_out_res;

    u2a_pkg::t_in_req  pending_reqs[$];   // requests waiting for the driver
    u2a_pkg::t_out_res expected_chars[$]; // characters predicted, not yet seen
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic              long_hold_req = 1'b0;
    int                fail_count = 0;

    unsigned_to_ascii_digits_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (o_out_res)
    );

    always #5 i_clk = ~i_clk;

    // Digit predictor: converts one request into its character sequence, MS digit first,
    // and appends it to the expected queue. Zero gives a lone '0'.
    function automatic void predict_digits(input u2a_pkg::t_in_req req);
        logic [31:0]       rem;
        logic [31:0]       radix;
        logic [3:0]        rev_digits[10];
        int                n;
        u2a_pkg::t_out_res ch;
        rem   = req.value & VALUE_MASK;
        radix = (req.func == FUNC_DEC) ? 32'd10 : 32'd16;
        n     = 0;
        if (rem == 32'd0) begin
            rev_digits[0] = 4'd0;
            n = 1;
        end
        while (rem != 32'd0) begin
            rev_digits[n] = 4'(rem % radix);
            rem = rem / radix;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            ch.digit_char = DIGIT_GLYPHS[8 * (15 - int'(rev_digits[k])) +: 7];
            ch.last_digit = (k == 0);
            expected_chars.push_back(ch);
        end
    endfunction

    // Random request: mix of narrow values (short digit runs), radix-power boundaries
    // (digit count steps) and full-width values.
    function automatic u2a_pkg::t_in_req rand_request();
        u2a_pkg::t_in_req req;
        logic [31:0]      p;
        int               w;
        req.func = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: begin
                w = $urandom_range(32, 1);
                req.value = $urandom & (32'hFFFF_FFFF >> (32 - w));
            end
            1: begin
                p = 32'd1;
                if (req.func == FUNC_DEC) begin
                    repeat ($urandom_range(9)) p = p * 32'd10;
                end else begin
                    repeat ($urandom_range(7)) p = p << 4;
                end
                req.value = p + 32'($urandom_range(2)) - 32'd1;
            end
            default: req.value = $urandom;
        endcase
        return req;
    endfunction

    task automatic queue_random(input int count);
        repeat (count) pending_reqs.push_back(rand_request());
    endtask

    // Wait until every request is sent and every predicted character has come back
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_chars.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver: predicts on each accepted request, then offers the next one
    // (or idles) only when the channel is free.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_digits(in_req);
            end
            if (!in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_req   <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Character monitor: checks each accepted character against the oldest prediction.
    // Also owns the long hold-off used to back the block up into its input.
    int   hold_left = 0;
    logic hold_done = 1'b0;
    always @(posedge i_clk) begin
        u2a_pkg::t_out_res exp_ch;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character 0x%0h", o_out_res.digit_char);
                    fail_count++;
                end else begin
                    exp_ch = expected_chars.pop_front();
                    if (o_out_res.digit_char !== exp_ch.digit_char) begin
                        $error("digit_char: expected 0x%0h, got 0x%0h",
                               exp_ch.digit_char, o_out_res.digit_char);
                        fail_count++;
                    end
                    if (o_out_res.last_digit !== exp_ch.last_digit) begin
                        $error("last_digit: expected %0b, got %0b",
                               exp_ch.last_digit, o_out_res.last_digit);
                        fail_count++;
                    end
                end
            end
            if (long_hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: any handshake resets the count
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, extremes, single digits, digit-count steps, letters a-f
        pending_reqs.push_back('{FUNC_HEX, 32'h0000_0000});
        pending_reqs.push_back('{FUNC_DEC, 32'd0});
        pending_reqs.push_back('{FUNC_HEX, 32'hFFFF_FFFF});
        pending_reqs.push_back('{FUNC_DEC, 32'hFFFF_FFFF});
        pending_reqs.push_back('{FUNC_HEX, 32'h0000_0001});
        pending_reqs.push_back('{FUNC_DEC, 32'd9});
        pending_reqs.push_back('{FUNC_DEC, 32'd10});
        pending_reqs.push_back('{FUNC_HEX, 32'h0000_000F});
        pending_reqs.push_back('{FUNC_HEX, 32'h0000_0010});
        pending_reqs.push_back('{FUNC_HEX, 32'h8000_0000});
        pending_reqs.push_back('{FUNC_DEC, 32'h8000_0000});
        pending_reqs.push_back('{FUNC_DEC, 32'd999_999_999});
        pending_reqs.push_back('{FUNC_DEC, 32'd1_000_000_000});
        pending_reqs.push_back('{FUNC_HEX, 32'hABCD_EF01});
        pending_reqs.push_back('{FUNC_HEX, 32'h0FED_CBA9});
        pending_reqs.push_back('{FUNC_HEX, 32'h1000_0000});
        pending_reqs.push_back('{FUNC_HEX, 32'h0FFF_FFFF});
        pending_reqs.push_back('{FUNC_DEC, 32'h5555_5555});
        pending_reqs.push_back('{FUNC_DEC, 32'hAAAA_AAAA});
        pending_reqs.push_back('{FUNC_HEX, 32'h5555_5555});
        pending_reqs.push_back('{FUNC_HEX, 32'hAAAA_AAAA});
        pending_reqs.push_back('{FUNC_DEC, 32'd1});

        // No idling
        queue_random(90);
        drain();

        // Sender mostly idle
        send_idle_pct  = 75;
        recv_stall_pct = 0;
        queue_random(90);
        drain();

        // Receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        queue_random(90);
        drain();

        // Light idling on both sides
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        queue_random(90);
        drain();

        // Pressure: receiver holds off while requests keep coming, filling the block
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  <= 1'b1;
        queue_random(30);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            $error("%0d predicted characters never arrived", expected_chars.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
